FILE: sv/cpr_pkg.sv
// Shared types and codes for the clock page replacement block.
package cpr_pkg;

  // Command codes carried on in_command
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TOUCH  = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

  // Result codes carried on out_status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  localparam int VICTIM_W = 6;
  localparam int SLOT_W   = 6;

  // Per-frame flag word
  typedef struct packed {
    logic pres;
    logic refd;
  } flags_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;   // clear one flag entry
    logic acc;   // take an input word, issue reads
    logic look;  // evaluate the command on read data
    logic link;  // second link write of an insert
    logic step;  // issue reads at the walk pointer
    logic walk;  // evaluate one frame under the walk pointer
    logic emit;  // load the output register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic go_link;
    logic go_step;
    logic found;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/clock_page_replacement_core.sv
// Top level of the clock (second-chance) page replacement block.
//
//   channel | ports                                  | word accepted when
//   --------+----------------------------------------+---------------------
//   in      | in_command, in_frame_slot               | in_valid & in_ready
//   out     | out_victim, out_status                  | out_valid & out_ready
//
// Remove, touch and an insert into an empty ring pass through S_LOOK and S_DONE after
// the accept; an insert behind an existing tail adds S_LINK for the tail link write.
// Select walks the ring from the hand, through S_STEP and S_WALK for every frame it
// inspects, as the reads of the flag and link memories are registered.
// After reset a pass over all NUM_FRAMES entries clears the flag memory; in_ready
// stays low until it ends. One word is worked at a time; a result waits in
// the output register, and a stalled output holds the next result in S_DONE.
module clock_page_replacement_core #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [cpr_pkg::SLOT_W-1:0]   in_frame_slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpr_pkg::VICTIM_W-1:0] out_victim,
  output logic [1:0]                   out_status
);
  import cpr_pkg::*;

  ctl_t  ctl;
  stat_t st;

  // Sequencer
  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  // Ring storage and results
  cpr_dpath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .st            (st),
    .in_command    (in_command),
    .in_frame_slot (in_frame_slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_victim    (out_victim),
    .out_status    (out_status)
  );

endmodule

FILE: sv/cpr_ctrl.sv
// Sequencer for the clock page replacement block.
module cpr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpr_pkg::stat_t st,
  output cpr_pkg::ctl_t  ctl
);
  import cpr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_LINK  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.acc   = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.look = 1'b1;
        if (st.go_link)      state_nxt = S_LINK;
        else if (st.go_step) state_nxt = S_STEP;
        else                 state_nxt = S_DONE;
      end
      S_LINK: begin
        ctl.link  = 1'b1;
        state_nxt = S_DONE;
      end
      S_STEP: begin
        ctl.step  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        ctl.walk  = 1'b1;
        state_nxt = st.found ? S_DONE : S_STEP;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

FILE: sv/cpr_dpath.sv
// Ring storage, pointers and result registers for the clock page replacement block.
module cpr_dpath #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cpr_pkg::ctl_t                  ctl,
  output cpr_pkg::stat_t                 st,
  input  logic [1:0]                     in_command,
  input  logic [cpr_pkg::SLOT_W-1:0]     in_frame_slot,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpr_pkg::VICTIM_W-1:0]   out_victim,
  output logic [1:0]                     out_status
);
  import cpr_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int LW = FW + 1;
  localparam logic [LW-1:0] NONE = LW'(NUM_FRAMES);

  // Memories
  flags_t        flags_mem [NUM_FRAMES];
  logic [LW-1:0] next_mem  [NUM_FRAMES];
  logic [LW-1:0] prev_mem  [NUM_FRAMES];

  logic          fl_we, nx_we, pv_we;
  logic [FW-1:0] fl_wa, nx_wa, pv_wa, rd_a;
  flags_t        fl_wd;
  logic [LW-1:0] nx_wd, pv_wd;

  flags_t        fl_rd_r;
  logic [LW-1:0] nx_rd_r, pv_rd_r;

  // Registers
  logic [1:0]          cmd_r;
  logic [FW-1:0]       fidx_r, h_r, h_nxt, clr_cnt_r;
  logic                fbad_r;
  logic [LW-1:0]       first_r, first_nxt, last_r, last_nxt, hand_r, hand_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [VICTIM_W-1:0] res_victim_r, res_victim_nxt;
  logic                out_valid_r;
  logic [VICTIM_W-1:0] out_victim_r;
  logic [1:0]          out_status_r;
  logic [LW-1:0]       fidx_l;
  logic [LW-1:0]       walk_next;

  assign fidx_l    = LW'(fidx_r);
  assign walk_next = (nx_rd_r == NONE) ? first_r : nx_rd_r;

  // Status to the controller
  always_comb begin
    st.clr_last = (clr_cnt_r == FW'(NUM_FRAMES - 1));
    st.go_link  = (cmd_r == CMD_INSERT) && !fbad_r && !fl_rd_r.pres && (last_r != NONE);
    st.go_step  = (cmd_r == CMD_SELECT) && (first_r != NONE);
    st.found    = !fl_rd_r.refd;
    st.out_free = !out_valid_r || out_ready;
  end

  // Read address: frame on accept (hand for select), walk pointer on a step
  always_comb begin
    rd_a = '0;
    if (ctl.step) rd_a = h_r;
    if (ctl.acc) begin
      if (in_command == CMD_SELECT) rd_a = hand_r[FW-1:0];
      else                          rd_a = FW'(in_frame_slot);
    end
  end

  // Command execution and memory writes
  always_comb begin
    fl_we = 1'b0; fl_wa = fidx_r; fl_wd = '0;
    nx_we = 1'b0; nx_wa = fidx_r; nx_wd = NONE;
    pv_we = 1'b0; pv_wa = fidx_r; pv_wd = last_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    hand_nxt       = hand_r;
    h_nxt          = h_r;
    res_status_nxt = res_status_r;
    res_victim_nxt = res_victim_r;

    if (ctl.clr) begin
      fl_we = 1'b1;
      fl_wa = clr_cnt_r;
    end

    if (ctl.look) begin
      res_status_nxt = ST_OK;
      res_victim_nxt = '0;
      if (cmd_r == CMD_SELECT) begin
        if (first_r == NONE) begin
          res_status_nxt = ST_EMPTY;
        end else if (hand_r == NONE) begin
          h_nxt = first_r[FW-1:0];
        end else begin
          h_nxt = walk_next[FW-1:0];
        end
      end else if (fbad_r) begin
        res_status_nxt = ST_ABSENT;
      end else begin
        case (cmd_r)
          CMD_INSERT: begin
            if (fl_rd_r.pres) begin
              res_status_nxt = ST_DUP;
            end else begin
              // append at the back; the old tail is linked in next cycle
              fl_we      = 1'b1;
              fl_wd.pres = 1'b1;
              nx_we      = 1'b1;
              pv_we      = 1'b1;
              if (last_r == NONE) begin
                first_nxt = fidx_l;
                last_nxt  = fidx_l;
              end
            end
          end
          CMD_TOUCH: begin
            if (!fl_rd_r.pres) begin
              res_status_nxt = ST_ABSENT;
            end else begin
              fl_we      = 1'b1;
              fl_wd.pres = 1'b1;
              fl_wd.refd = 1'b1;
            end
          end
          default: begin
            if (!fl_rd_r.pres) begin
              res_status_nxt = ST_ABSENT;
            end else begin
              // unlink; a hand on this frame falls back to its predecessor (none at the head)
              fl_we = 1'b1;
              if (hand_r == fidx_l) hand_nxt = pv_rd_r;
              if (pv_rd_r == NONE) begin
                first_nxt = nx_rd_r;
              end else begin
                nx_we = 1'b1;
                nx_wa = pv_rd_r[FW-1:0];
                nx_wd = nx_rd_r;
              end
              if (nx_rd_r == NONE) begin
                last_nxt = pv_rd_r;
              end else begin
                pv_we = 1'b1;
                pv_wa = nx_rd_r[FW-1:0];
                pv_wd = pv_rd_r;
              end
            end
          end
        endcase
      end
    end

    if (ctl.link) begin
      nx_we    = 1'b1;
      nx_wa    = last_r[FW-1:0];
      nx_wd    = fidx_l;
      last_nxt = fidx_l;
    end

    if (ctl.walk) begin
      if (fl_rd_r.refd) begin
        // second chance: clear and move on
        fl_we      = 1'b1;
        fl_wa      = h_r;
        fl_wd.pres = 1'b1;
        h_nxt      = walk_next[FW-1:0];
      end else begin
        hand_nxt       = LW'(h_r);
        res_status_nxt = ST_OK;
        res_victim_nxt = VICTIM_W'(h_r);
      end
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (fl_we) flags_mem[fl_wa] <= fl_wd;
    if (nx_we) next_mem[nx_wa]  <= nx_wd;
    if (pv_we) prev_mem[pv_wa]  <= pv_wd;
    fl_rd_r <= flags_mem[rd_a];
    nx_rd_r <= next_mem[rd_a];
    pv_rd_r <= prev_mem[rd_a];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      cmd_r  <= in_command;
      fidx_r <= FW'(in_frame_slot);
      fbad_r <= (32'(in_frame_slot) >= NUM_FRAMES);
    end
    h_r          <= h_nxt;
    res_status_r <= res_status_nxt;
    res_victim_r <= res_victim_nxt;
    if (ctl.emit) begin
      out_victim_r <= res_victim_r;
      out_status_r <= res_status_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= NONE;
      last_r      <= NONE;
      hand_r      <= NONE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      hand_r  <= hand_nxt;
      if (ctl.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctl.emit)          out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_victim = out_victim_r;
  assign out_status = out_status_r;

endmodule
